// File: hw/rtl/csvl_pkg.sv
package csvl_pkg;

  typedef enum logic [2:0] {
    MODE_BLANK  = 3'd0,
    MODE_FIELD  = 3'd1,
    MODE_QUOTED = 3'd2,
    MODE_QSEEN  = 3'd3,
    MODE_DELIM  = 3'd4
  } lex_mode_t;

  typedef enum logic [2:0] {
    TT_NONE    = 3'd0,
    TT_INT     = 3'd1,
    TT_FLOAT   = 3'd2,
    TT_STRING  = 3'd3,
    TT_ERROR   = 3'd4,
    TT_NEWLINE = 3'd5,
    TT_EOB     = 3'd6
  } tok_type_t;

  localparam logic KIND_CHAR = 1'b0;
  localparam logic KIND_TOKEN = 1'b1;

  localparam logic [7:0] CH_COMMA   = 8'h2C;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_QUOTE   = 8'h22;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_DOT     = 8'h2E;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_BANG    = 8'h21;
  localparam logic [7:0] CH_TILDE   = 8'h7E;
  localparam logic [7:0] CH_NUL     = 8'h00;

  typedef struct packed {
    logic       saw_digit;
    logic [1:0] dot_count;
    logic       saw_other;
    logic       text_nonempty;
  } field_flags_t;

  typedef struct packed {
    logic       result_kind;
    logic [7:0] text_char;
    tok_type_t  token_type;
    logic       last_of_run;
  } lex_res_t;

  function automatic tok_type_t classify(field_flags_t f);
    tok_type_t t;
    if (f.saw_other || f.dot_count > 2'd1) begin
      t = TT_STRING;
    end else if (f.dot_count != 2'd0) begin
      t = f.saw_digit ? TT_FLOAT : TT_STRING;
    end else if (f.saw_digit) begin
      t = TT_INT;
    end else begin
      t = f.text_nonempty ? TT_STRING : TT_NONE;
    end
    return t;
  endfunction

  function automatic lex_res_t mk_res(logic kind, logic [7:0] ch, tok_type_t tt);
    lex_res_t r;
    r.result_kind = kind;
    r.text_char   = ch;
    r.token_type  = tt;
    r.last_of_run = 1'b0;
    return r;
  endfunction

endpackage

// File: hw/rtl/csvl_if.sv
interface csvl_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       buffer_end;

  modport source (output valid, output data_byte, output buffer_end, input ready);
  modport sink (input valid, input data_byte, input buffer_end, output ready);
endinterface

interface csvl_out_if;
  logic       valid;
  logic       ready;
  logic       result_kind;
  logic [7:0] text_char;
  logic [2:0] token_type;
  logic       last_of_run;

  modport source (output valid, output result_kind, output text_char,
                  output token_type, output last_of_run, input ready);
  modport sink (input valid, input result_kind, input text_char,
                input token_type, input last_of_run, output ready);
endinterface

// File: hw/rtl/csv_field_lexer.sv
// csv_field_lexer: byte-stream lexer for comma-separated lines.
// in_if carries one buffer byte per transaction (data_byte), or an end-of-buffer
// mark (buffer_end = 1, byte ignored). out_if carries result transactions:
// a token character (result_kind 0) or a completed token with its type
// (result_kind 1); last_of_run flags the final result caused by one input.
// Each input gives zero, one or two results.
// out_if offers the head of the result queue. The lexer state updates in the
// accepting cycle and the results enter a 4-entry result queue, so a new byte
// can be taken every cycle while the queue has room; the sustained rate is one
// input per cycle while inputs give at most one result each and the receiver
// is ready, and the single-result output port sets the limit at one result
// per cycle otherwise.
// in_if.ready is high while the queue has room for two results. When the
// receiver stalls, queued results hold and input is taken until fewer than two
// entries are free, then in_if.ready drops.
// Reset (rst_n low, synchronous) empties the queue and returns the lexer to
// leading-blank skip with all field flags cleared.
module csv_field_lexer
  import csvl_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  csvl_in_if.sink    in_if,
  csvl_out_if.source out_if
);

  localparam int unsigned QDEPTH = 4;

  lex_mode_t    mode_r, mode_nxt;
  field_flags_t flags_r, flags_nxt;
  logic         since_r, since_nxt;

  lex_res_t     res_a [2];
  logic [1:0]   res_n;

  lex_res_t     q_r [QDEPTH];
  logic [1:0]   wr_ptr_r, rd_ptr_r;
  logic [2:0]   cnt_r, cnt_nxt;

  logic         accept, pop;
  logic [7:0]   c;
  logic         printable, graphic, is_digit;
  logic         do_field, do_keep, do_finish, do_tail, saw_nl;

  assign c         = in_if.data_byte;
  assign printable = (c >= CH_SPACE) && (c <= CH_TILDE);
  assign graphic   = (c >= CH_BANG) && (c <= CH_TILDE);
  assign is_digit  = (c >= CH_ZERO) && (c <= CH_NINE);

  assign in_if.ready = (cnt_r <= 3'(QDEPTH - 2));
  assign accept      = in_if.valid && in_if.ready;
  assign pop         = out_if.valid && out_if.ready;

  // per-byte lexing step
  always_comb begin
    mode_nxt  = mode_r;
    flags_nxt = flags_r;
    since_nxt = since_r;
    res_a[0]  = mk_res(KIND_CHAR, CH_NUL, TT_NONE);
    res_a[1]  = mk_res(KIND_CHAR, CH_NUL, TT_NONE);
    res_n     = 2'd0;
    do_field  = 1'b0;
    do_keep   = 1'b0;
    do_finish = 1'b0;
    do_tail   = 1'b0;
    saw_nl    = 1'b0;

    if (in_if.buffer_end) begin
      priority if (mode_r == MODE_QUOTED) begin
        res_a[0] = mk_res(KIND_TOKEN, CH_NUL, TT_ERROR);
        res_n    = 2'd1;
      end else if (mode_r == MODE_FIELD || mode_r == MODE_QSEEN) begin
        res_a[0] = mk_res(KIND_TOKEN, CH_NUL, classify(flags_r));
        res_n    = 2'd1;
      end else if (since_r) begin
        res_a[0] = mk_res(KIND_TOKEN, CH_NUL, TT_NONE);
        res_n    = 2'd1;
      end else begin
        res_n    = 2'd0;
      end
      res_a[res_n[0]] = mk_res(KIND_TOKEN, CH_NUL, TT_EOB);
      res_n     = res_n + 2'd1;
      mode_nxt  = MODE_BLANK;
      flags_nxt = '0;
      since_nxt = 1'b0;
    end else begin
      unique case (mode_r)
        MODE_FIELD: begin
          do_field = 1'b1;
        end
        MODE_QUOTED: begin
          if (c == CH_QUOTE) begin
            mode_nxt = MODE_QSEEN;
          end else begin
            do_keep = 1'b1;
          end
        end
        MODE_QSEEN: begin
          if (c == CH_QUOTE) begin
            flags_nxt.saw_other     = 1'b1;
            flags_nxt.text_nonempty = 1'b1;
            res_a[0] = mk_res(KIND_CHAR, c, TT_NONE);
            res_n    = 2'd1;
            mode_nxt = MODE_QUOTED;
          end else begin
            do_finish = 1'b1;
          end
        end
        MODE_DELIM: begin
          do_tail = 1'b1;
        end
        default: begin
          mode_nxt = MODE_BLANK;
          if (graphic || c == CH_NEWLINE) begin
            priority if (c == CH_QUOTE) begin
              mode_nxt = MODE_QUOTED;
            end else if (c == CH_PLUS || c == CH_MINUS) begin
              flags_nxt.text_nonempty = 1'b1;
              res_a[0] = mk_res(KIND_CHAR, c, TT_NONE);
              res_n    = 2'd1;
              mode_nxt = MODE_FIELD;
            end else begin
              mode_nxt = MODE_FIELD;
              do_field = 1'b1;
            end
          end
        end
      endcase

      if (do_field) begin
        if (printable && c != CH_QUOTE && c != CH_COMMA) begin
          do_keep = 1'b1;
        end else begin
          do_finish = 1'b1;
        end
      end

      if (do_keep) begin
        priority if (is_digit) begin
          flags_nxt.saw_digit = 1'b1;
        end else if (c == CH_DOT) begin
          if (flags_r.dot_count < 2'd2) begin
            flags_nxt.dot_count = flags_r.dot_count + 2'd1;
          end
        end else begin
          flags_nxt.saw_other = 1'b1;
        end
        flags_nxt.text_nonempty = 1'b1;
        res_a[0] = mk_res(KIND_CHAR, c, TT_NONE);
        res_n    = 2'd1;
      end

      if (do_finish) begin
        res_a[0]  = mk_res(KIND_TOKEN, CH_NUL, classify(flags_r));
        res_n     = 2'd1;
        flags_nxt = '0;
        mode_nxt  = MODE_DELIM;
        do_tail   = 1'b1;
      end

      if (do_tail) begin
        if (c == CH_COMMA) begin
          mode_nxt = MODE_BLANK;
        end else if (c == CH_NEWLINE) begin
          res_a[res_n[0]] = mk_res(KIND_TOKEN, CH_NEWLINE, TT_NEWLINE);
          res_n    = res_n + 2'd1;
          mode_nxt = MODE_BLANK;
          saw_nl   = 1'b1;
        end
      end

      since_nxt = !saw_nl;
    end

    res_a[0].last_of_run = (res_n == 2'd1);
    res_a[1].last_of_run = (res_n == 2'd2);
  end

  // result queue
  always_comb begin
    cnt_nxt = cnt_r;
    if (accept) begin
      cnt_nxt = cnt_nxt + {1'b0, res_n};
    end
    if (pop) begin
      cnt_nxt = cnt_nxt - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_BLANK;
      flags_r  <= '0;
      since_r  <= 1'b0;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (accept) begin
        mode_r   <= mode_nxt;
        flags_r  <= flags_nxt;
        since_r  <= since_nxt;
        wr_ptr_r <= wr_ptr_r + res_n;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && res_n != 2'd0) begin
      q_r[wr_ptr_r] <= res_a[0];
    end
    if (accept && res_n == 2'd2) begin
      q_r[wr_ptr_r + 2'd1] <= res_a[1];
    end
  end

  assign out_if.valid       = (cnt_r != 3'd0);
  assign out_if.result_kind = q_r[rd_ptr_r].result_kind;
  assign out_if.text_char   = q_r[rd_ptr_r].text_char;
  assign out_if.token_type  = q_r[rd_ptr_r].token_type;
  assign out_if.last_of_run = q_r[rd_ptr_r].last_of_run;

endmodule
